@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge while out of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that an antecedent is followed by a consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/kphr_pkg.sv @@
package kphr_pkg;

  localparam int unsigned DepthDefault = 16;
  localparam int unsigned FrameW       = 32;
  localparam int unsigned AngleW       = 32;
  localparam int unsigned TimeW        = 64;
  localparam int unsigned CountW       = 32;

  localparam logic FUNC_RECORD = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef struct packed {
    logic [FrameW-1:0] frame;
    logic [AngleW-1:0] hor;
    logic [AngleW-1:0] ver;
    logic [TimeW-1:0]  tms;
  } entry_t;

  typedef struct packed {
    logic push;   // take the neighbour on the newer side
    logic rot;    // take the neighbour on the older side
  } cell_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

endpackage

@@ rtl/kphr_cell.sv @@
module kphr_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kphr_pkg::cell_ctrl_t ctrl_i,
  input  kphr_pkg::entry_t    push_i,
  input  kphr_pkg::entry_t    rot_i,
  output kphr_pkg::entry_t    entry_o
);

  kphr_pkg::entry_t            entry_d;
  logic [kphr_pkg::FrameW-1:0] frame_q;
  logic [kphr_pkg::AngleW-1:0] hor_q;
  logic [kphr_pkg::AngleW-1:0] ver_q;
  logic [kphr_pkg::TimeW-1:0]  tms_q;

  assign entry_o = '{frame: frame_q, hor: hor_q, ver: ver_q, tms: tms_q};

  always_comb begin
    entry_d = entry_o;
    priority if (ctrl_i.push) begin
      entry_d = push_i;
    end else if (ctrl_i.rot) begin
      entry_d = rot_i;
    end else begin
      entry_d = entry_o;
    end
  end

  // time of zero marks the slot empty, so only the time is cleared
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tms_q <= '0;
    end else begin
      tms_q <= entry_d.tms;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= entry_d.frame;
    hor_q   <= entry_d.hor;
    ver_q   <= entry_d.ver;
  end

endmodule

@@ rtl/keyed_pose_history_ring.sv @@
// Record: accepted while idle, result strobe on done_o the next cycle; busy_o stays low.
// Lookup: the cell chain rotates once per cycle past the head comparator until every entry
// has passed it, then done_o pulses; busy_o is high for the scan, starts taken only when idle.
// Reset clears all capture times, the record count and the control state.
// Results cannot be stalled: done_o is high for a single cycle; the word then stays on the ports until the next start.
module keyed_pose_history_ring #(
  parameter int unsigned DEPTH = kphr_pkg::DepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          func_i,
  input  logic [kphr_pkg::FrameW-1:0]   frame_id_i,
  input  logic [kphr_pkg::AngleW-1:0]   hor_angle_bits_i,
  input  logic [kphr_pkg::AngleW-1:0]   ver_angle_bits_i,
  input  logic [kphr_pkg::TimeW-1:0]    capture_time_ms_i,
  output logic                          done_o,
  output logic                          found_o,
  output logic [kphr_pkg::FrameW-1:0]   match_frame_id_o,
  output logic [kphr_pkg::AngleW-1:0]   match_hor_bits_o,
  output logic [kphr_pkg::AngleW-1:0]   match_ver_bits_o,
  output logic [kphr_pkg::TimeW-1:0]    match_time_ms_o,
  output logic [kphr_pkg::CountW-1:0]   record_count_o
);

  `include "assert_macros.svh"

  localparam int unsigned CntW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CntW-1:0] LastStep = CntW'(DEPTH - 1);

  kphr_pkg::state_e state_d, state_q;
  logic [CntW-1:0]  step_d, step_q;
  logic             done_d, done_q;
  logic             found_d, found_q;
  logic [kphr_pkg::CountW-1:0] count_d, count_q;
  logic [kphr_pkg::FrameW-1:0] key_d, key_q;
  kphr_pkg::entry_t match_d, match_q;
  kphr_pkg::entry_t new_entry;
  kphr_pkg::cell_ctrl_t ctrl;
  kphr_pkg::entry_t cells [DEPTH];

  assign new_entry = '{frame: frame_id_i, hor: hor_angle_bits_i,
                       ver: ver_angle_bits_i, tms: capture_time_ms_i};

  // cell 0 holds the newest entry; push moves towards the oldest end,
  // rotate brings each older entry to the head in turn
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    kphr_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .push_i  ((g == 0) ? new_entry : cells[(g + DEPTH - 1) % DEPTH]),
      .rot_i   (cells[(g + 1) % DEPTH]),
      .entry_o (cells[g])
    );
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    done_d  = 1'b0;
    found_d = found_q;
    count_d = count_q;
    key_d   = key_q;
    match_d = match_q;
    ctrl    = '0;
    unique case (state_q)
      kphr_pkg::ST_IDLE: begin
        if (start_i) begin
          found_d = 1'b0;
          match_d = '0;
          if (func_i == kphr_pkg::FUNC_LOOKUP) begin
            key_d   = frame_id_i;
            step_d  = '0;
            state_d = kphr_pkg::ST_SCAN;
          end else begin
            ctrl.push = 1'b1;
            if (count_q != '1) begin
              count_d = count_q + 1'b1;
            end
            done_d = 1'b1;
          end
        end
      end
      kphr_pkg::ST_SCAN: begin
        ctrl.rot = 1'b1;
        // keep the first hit only: that is the newest
        if (!found_q && (cells[0].tms != '0) && (cells[0].frame == key_q)) begin
          found_d = 1'b1;
          match_d = cells[0];
        end
        step_d = step_q + 1'b1;
        if (step_q == LastStep) begin
          state_d = kphr_pkg::ST_IDLE;
          done_d  = 1'b1;
        end
      end
      default: state_d = kphr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kphr_pkg::ST_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
      found_q <= 1'b0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      done_q  <= done_d;
      found_q <= found_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    match_q <= match_d;
  end

  assign busy_o           = (state_q != kphr_pkg::ST_IDLE);
  assign done_o           = done_q;
  assign found_o          = found_q;
  assign match_frame_id_o = match_q.frame;
  assign match_hor_bits_o = match_q.hor;
  assign match_ver_bits_o = match_q.ver;
  assign match_time_ms_o  = match_q.tms;
  assign record_count_o   = count_q;

  `ASSERT_NEXT(a_scan_ends_in_done,
               (state_q == kphr_pkg::ST_SCAN) && (step_q == LastStep),
               done_o && !busy_o, "lookup scan did not end in a result")
  `ASSERT_NEXT(a_lookup_goes_busy,
               start_i && !busy_o && (func_i == kphr_pkg::FUNC_LOOKUP),
               busy_o && !done_o, "lookup start did not enter the scan")
  `ASSERT_CLK(a_hit_has_time, !found_o || (match_time_ms_o != '0),
              "hit reported on an empty slot")
  `ASSERT_CLK(a_count_steps,
              (record_count_o == $past(record_count_o)) ||
              (record_count_o == $past(record_count_o) + 32'd1),
              "record count moved by more than one")

endmodule

@@ tb/keyed_pose_history_ring_test.sv @@
module keyed_pose_history_ring_test;

  localparam int unsigned Slots      = kphr_pkg::DepthDefault;
  localparam int unsigned RandWords  = 400;
  localparam int unsigned StallLimit = 2000;

  typedef struct packed {
    logic                        op;
    logic [kphr_pkg::FrameW-1:0] key;
    logic [kphr_pkg::AngleW-1:0] hor;
    logic [kphr_pkg::AngleW-1:0] ver;
    logic [kphr_pkg::TimeW-1:0]  stamp;
  } pose_cmd_t;

  typedef struct packed {
    logic                        hit;
    logic [kphr_pkg::FrameW-1:0] key;
    logic [kphr_pkg::AngleW-1:0] hor;
    logic [kphr_pkg::AngleW-1:0] ver;
    logic [kphr_pkg::TimeW-1:0]  stamp;
    logic [kphr_pkg::CountW-1:0] count;
  } pose_reply_t;

  // Shadow copy of the ring; works out the reply each accepted word must give.
  class pose_ring_shadow;
    logic [kphr_pkg::FrameW-1:0] keys[Slots];
    logic [kphr_pkg::AngleW-1:0] hors[Slots];
    logic [kphr_pkg::AngleW-1:0] vers[Slots];
    logic [kphr_pkg::TimeW-1:0]  stamps[Slots];
    int unsigned                 write_ptr;
    logic [kphr_pkg::CountW-1:0] tally;
    pose_reply_t                 replies_due[$];
    int unsigned                 fails;
    int unsigned                 records;
    int unsigned                 hits;
    int unsigned                 misses;

    function new();
      foreach (stamps[i]) begin
        stamps[i] = '0;
        keys[i]   = '0;
        hors[i]   = '0;
        vers[i]   = '0;
      end
      write_ptr = 0;
      tally     = '0;
      fails     = 0;
      records   = 0;
      hits      = 0;
      misses    = 0;
    endfunction

    function void take_command(pose_cmd_t c);
      pose_reply_t r;
      int unsigned idx;
      r = '0;
      if (c.op == kphr_pkg::FUNC_RECORD) begin
        keys[write_ptr]   = c.key;
        hors[write_ptr]   = c.hor;
        vers[write_ptr]   = c.ver;
        stamps[write_ptr] = c.stamp;
        write_ptr = (write_ptr + 1) % Slots;
        if (tally != '1) tally++;
        records++;
      end else begin
        // walk newest to oldest, skip slots with no capture time
        for (int k = 0; k < Slots; k++) begin
          idx = (write_ptr + 2 * Slots - 1 - k) % Slots;
          if (stamps[idx] == '0) continue;
          if (keys[idx] == c.key) begin
            r.hit   = 1'b1;
            r.key   = keys[idx];
            r.hor   = hors[idx];
            r.ver   = vers[idx];
            r.stamp = stamps[idx];
            break;
          end
        end
        if (r.hit) hits++;
        else misses++;
      end
      r.count = tally;
      replies_due.push_back(r);
    endfunction

    function void check_field(string what, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        fails++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      end
    endfunction

    function void match_reply(pose_reply_t got);
      pose_reply_t want;
      if (replies_due.size() == 0) begin
        fails++;
        $display("%0t: unexpected result word, expected none, got %0h", $time, got);
        return;
      end
      want = replies_due.pop_front();
      check_field("found",          64'(want.hit),   64'(got.hit));
      check_field("match_frame_id", 64'(want.key),   64'(got.key));
      check_field("match_hor_bits", 64'(want.hor),   64'(got.hor));
      check_field("match_ver_bits", 64'(want.ver),   64'(got.ver));
      check_field("match_time_ms",  want.stamp,      got.stamp);
      check_field("record_count",   64'(want.count), 64'(got.count));
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start_i;
  logic                        busy_o;
  logic                        func_i;
  logic [kphr_pkg::FrameW-1:0] frame_id_i;
  logic [kphr_pkg::AngleW-1:0] hor_angle_bits_i;
  logic [kphr_pkg::AngleW-1:0] ver_angle_bits_i;
  logic [kphr_pkg::TimeW-1:0]  capture_time_ms_i;
  logic                        done_o;
  logic                        found_o;
  logic [kphr_pkg::FrameW-1:0] match_frame_id_o;
  logic [kphr_pkg::AngleW-1:0] match_hor_bits_o;
  logic [kphr_pkg::AngleW-1:0] match_ver_bits_o;
  logic [kphr_pkg::TimeW-1:0]  match_time_ms_o;
  logic [kphr_pkg::CountW-1:0] record_count_o;

  pose_ring_shadow             sb;
  logic [kphr_pkg::FrameW-1:0] key_pool[8];
  int unsigned                 idle_run;

  keyed_pose_history_ring dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .func_i            (func_i),
    .frame_id_i        (frame_id_i),
    .hor_angle_bits_i  (hor_angle_bits_i),
    .ver_angle_bits_i  (ver_angle_bits_i),
    .capture_time_ms_i (capture_time_ms_i),
    .done_o            (done_o),
    .found_o           (found_o),
    .match_frame_id_o  (match_frame_id_o),
    .match_hor_bits_o  (match_hor_bits_o),
    .match_ver_bits_o  (match_ver_bits_o),
    .match_time_ms_o   (match_time_ms_o),
    .record_count_o    (record_count_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      sb.match_reply('{found_o, match_frame_id_o, match_hor_bits_o, match_ver_bits_o,
                       match_time_ms_o, record_count_o});
    end
  end

  // abort if neither side moves a word for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
      if (idle_run == StallLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic pose_cmd_t make_cmd(logic op, logic [kphr_pkg::FrameW-1:0] key,
                                         logic [kphr_pkg::AngleW-1:0] hor,
                                         logic [kphr_pkg::AngleW-1:0] ver,
                                         logic [kphr_pkg::TimeW-1:0] stamp);
    pose_cmd_t c;
    c.op    = op;
    c.key   = key;
    c.hor   = hor;
    c.ver   = ver;
    c.stamp = stamp;
    return c;
  endfunction

  // Mostly keys from a small pool so that lookups find recent records.
  function automatic pose_cmd_t rand_word();
    pose_cmd_t c;
    c.op  = ($urandom_range(0, 99) < 55) ? kphr_pkg::FUNC_RECORD : kphr_pkg::FUNC_LOOKUP;
    c.key = ($urandom_range(0, 4) != 0) ? key_pool[$urandom_range(0, 7)] : $urandom;
    c.hor = $urandom;
    c.ver = $urandom;
    case ($urandom_range(0, 9))
      0: c.stamp = '0;
      1: c.stamp = '1;
      default: c.stamp = {$urandom, $urandom};
    endcase
    return c;
  endfunction

  task automatic send_word(input pose_cmd_t c, input bit no_gaps);
    while (!no_gaps && $urandom_range(0, 99) < 24) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
    @(negedge clk_i);
    start_i           <= 1'b1;
    func_i            <= c.op;
    frame_id_i        <= c.key;
    hor_angle_bits_i  <= c.hor;
    ver_angle_bits_i  <= c.ver;
    capture_time_ms_i <= c.stamp;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.take_command(c);
  endtask

  task automatic drain_replies();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (sb.replies_due.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    start_i           = 1'b0;
    func_i            = kphr_pkg::FUNC_RECORD;
    frame_id_i        = '0;
    hor_angle_bits_i  = '0;
    ver_angle_bits_i  = '0;
    capture_time_ms_i = '0;
    sb = new();
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 32'd1;
    key_pool[3] = 32'd2;
    for (int i = 4; i < 8; i++) key_pool[i] = $urandom;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty ring: nothing may match, not even frame id zero
    send_word(make_cmd(kphr_pkg::FUNC_LOOKUP, '0, '1, '1, '1), 1'b0);
    send_word(make_cmd(kphr_pkg::FUNC_LOOKUP, '1, '0, '0, '0), 1'b0);
    // a zero capture time leaves the slot empty
    send_word(make_cmd(kphr_pkg::FUNC_RECORD, '0, '0, '0, '0), 1'b0);
    send_word(make_cmd(kphr_pkg::FUNC_LOOKUP, '0, '0, '0, '0), 1'b0);
    send_word(make_cmd(kphr_pkg::FUNC_RECORD, '1, '1, '0, '1), 1'b0);
    send_word(make_cmd(kphr_pkg::FUNC_LOOKUP, '1, '0, '0, '0), 1'b0);
    send_word(make_cmd(kphr_pkg::FUNC_RECORD, '0, '0, '1, 64'd1), 1'b0);
    send_word(make_cmd(kphr_pkg::FUNC_LOOKUP, '0, '1, '1, '1), 1'b0);
    // duplicate keys: the newest one wins, unless its time is zero
    send_word(make_cmd(kphr_pkg::FUNC_RECORD, 32'd5, 32'ha5a5a5a5, 32'h5a5a5a5a, 64'd100),
              1'b0);
    send_word(make_cmd(kphr_pkg::FUNC_RECORD, 32'd5, 32'h12345678, 32'h9abcdef0, 64'd200),
              1'b0);
    send_word(make_cmd(kphr_pkg::FUNC_LOOKUP, 32'd5, '0, '0, '0), 1'b0);
    send_word(make_cmd(kphr_pkg::FUNC_RECORD, 32'd5, 32'hdeadbeef, 32'hcafef00d, '0), 1'b0);
    send_word(make_cmd(kphr_pkg::FUNC_LOOKUP, 32'd5, '0, '0, '0), 1'b0);
    send_word(make_cmd(kphr_pkg::FUNC_LOOKUP, 32'd6, '0, '0, '0), 1'b0);
    drain_replies();

    for (int n = 0; n < RandWords; n++) begin
      // hold off until every reply is in, twice during the run
      if (n == 100 || n == 300) drain_replies();
      send_word(rand_word(), n >= 150 && n < 260);
    end
    drain_replies();
    repeat (Slots + 4) @(posedge clk_i);

    if (sb.replies_due.size() != 0) begin
      sb.fails++;
      $display("%0t: %0d result words never arrived", $time, sb.replies_due.size());
    end
    $display("Sent %0d records and %0d lookups (%0d hits, %0d misses)",
             sb.records, sb.hits + sb.misses, sb.hits, sb.misses);
    $display("Ring wrapped %0d times, final record count %0d",
             sb.records / Slots, sb.tally);
    if (sb.fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
